[rtl/frp_pkg.sv]
// shared constants and types for the framed packet receiver
package frp_pkg;

    localparam int BYTE_W      = 8;
    localparam int SUM_W       = 16;
    localparam int LEN_W       = 7;
    localparam int MAX_PAYLOAD = 64;
    localparam int PAY_AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int TDATA_W     = 32;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h3A;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'h0D;

    // register indexes on the config port
    localparam logic CFG_BOARD_ADDR  = 1'b0;
    localparam logic CFG_LISTEN_ADDR = 1'b1;

    // header of an accepted frame, handed from parser to emitter
    typedef struct packed {
        logic [BYTE_W-1:0] slave;
        logic [BYTE_W-1:0] command;
        logic [LEN_W-1:0]  length;
    } frame_t;

endpackage

[rtl/frp_payload_ram.sv]
// simple dual port payload ram, one write and one registered read port
module frp_payload_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/frp_parser.sv]
// byte-level frame parser: hunt, header, payload store, checksum and accept check
module frp_parser
    import frp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,
    input  logic [BYTE_W-1:0]  own_addr,
    input  logic [BYTE_W-1:0]  listen_all_address,
    input  logic               emit_busy,
    output logic               ram_we,
    output logic [PAY_AW-1:0]  ram_waddr,
    output logic [BYTE_W-1:0]  ram_wdata,
    output logic               emit_start,
    output frame_t             emit_frame
);

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_SLAVE = 3'd1;
    localparam logic [2:0] PH_CMD   = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CKHI  = 3'd5;
    localparam logic [2:0] PH_CKLO  = 3'd6;
    localparam logic [2:0] PH_END   = 3'd7;

    logic [2:0]        phase_reg, phase_next;
    logic [BYTE_W-1:0] slave_reg, slave_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [BYTE_W-1:0] taken_reg, taken_next;
    logic [SUM_W-1:0]  run_sum_reg, run_sum_next;
    logic [SUM_W-1:0]  rcv_sum_reg, rcv_sum_next;

    logic              accept;
    logic [SUM_W-1:0]  sum_plus_byte;
    logic [SUM_W-1:0]  expect_sum;
    logic              addr_pass;
    logic              frame_ok;

    // no new byte while a frame is being read out of the store
    assign s_tready      = !emit_busy;
    assign accept        = s_tvalid && s_tready;
    assign sum_plus_byte = run_sum_reg + {{(SUM_W-BYTE_W){1'b0}}, s_tdata};
    assign expect_sum    = run_sum_reg + {{(SUM_W-BYTE_W){1'b0}}, END_BYTE};
    assign addr_pass     = (slave_reg == own_addr) ||
                           (own_addr == listen_all_address);
    assign frame_ok      = (s_tdata == END_BYTE) && (expect_sum == rcv_sum_reg) &&
                           addr_pass && (len_reg <= BYTE_W'(MAX_PAYLOAD));

    assign ram_we    = accept && (phase_reg == PH_DATA) &&
                       (taken_reg < BYTE_W'(MAX_PAYLOAD));
    assign ram_waddr = taken_reg[PAY_AW-1:0];
    assign ram_wdata = s_tdata;

    assign emit_start         = accept && (phase_reg == PH_END) && frame_ok;
    assign emit_frame.slave   = slave_reg;
    assign emit_frame.command = cmd_reg;
    assign emit_frame.length  = len_reg[LEN_W-1:0];

    always_comb begin
        phase_next   = phase_reg;
        slave_next   = slave_reg;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        taken_next   = taken_reg;
        run_sum_next = run_sum_reg;
        rcv_sum_next = rcv_sum_reg;
        if (accept) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (s_tdata == START_BYTE) begin
                        run_sum_next = {{(SUM_W-BYTE_W){1'b0}}, START_BYTE};
                        taken_next   = '0;
                        phase_next   = PH_SLAVE;
                    end
                end
                PH_SLAVE: begin
                    slave_next   = s_tdata;
                    run_sum_next = sum_plus_byte;
                    phase_next   = PH_CMD;
                end
                PH_CMD: begin
                    cmd_next     = s_tdata;
                    run_sum_next = sum_plus_byte;
                    phase_next   = PH_LEN;
                end
                PH_LEN: begin
                    len_next     = s_tdata;
                    taken_next   = '0;
                    run_sum_next = sum_plus_byte;
                    phase_next   = (s_tdata == '0) ? PH_CKHI : PH_DATA;
                end
                PH_DATA: begin
                    run_sum_next = sum_plus_byte;
                    taken_next   = taken_reg + 1'b1;
                    if (taken_next >= len_reg) begin
                        phase_next = PH_CKHI;
                    end
                end
                PH_CKHI: begin
                    rcv_sum_next = {s_tdata, {(SUM_W-BYTE_W){1'b0}}};
                    phase_next   = PH_CKLO;
                end
                PH_CKLO: begin
                    rcv_sum_next = rcv_sum_reg + {{(SUM_W-BYTE_W){1'b0}}, s_tdata};
                    phase_next   = PH_END;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        slave_reg   <= slave_next;
        cmd_reg     <= cmd_next;
        len_reg     <= len_next;
        taken_reg   <= taken_next;
        run_sum_reg <= run_sum_next;
        rcv_sum_reg <= rcv_sum_next;
    end

endmodule

[rtl/frp_emitter.sv]
// payload readout: streams the stored payload of an accepted frame
module frp_emitter
    import frp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               emit_start,
    input  frame_t             emit_frame,
    output logic               emit_busy,
    output logic               ram_re,
    output logic [PAY_AW-1:0]  ram_raddr,
    input  logic [BYTE_W-1:0]  ram_rdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    logic              busy_reg, busy_next;
    frame_t            frame_reg, frame_next;
    logic [LEN_W-1:0]  iss_cnt_reg, iss_cnt_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic              pend_empty_reg, pend_empty_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_bvalid_reg, out_bvalid_next;
    logic              out_last_reg, out_last_next;

    logic [LEN_W-1:0]  n_items;
    logic              can_move;
    logic              can_issue;
    logic              last_taken;

    // an empty payload still gives one word
    assign n_items    = (frame_reg.length == '0) ? LEN_W'(1) : frame_reg.length;
    // ram output register acts as a skid stage in front of the output register
    assign can_move   = pend_reg && (!out_valid_reg || m_tready);
    assign can_issue  = busy_reg && (iss_cnt_reg < n_items) && (!pend_reg || can_move);
    assign last_taken = out_valid_reg && m_tready && out_last_reg;

    assign ram_re    = can_issue;
    assign ram_raddr = iss_cnt_reg[PAY_AW-1:0];
    assign emit_busy = busy_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W-3*BYTE_W-LEN_W){1'b0}}, out_byte_reg, frame_reg.length,
                       frame_reg.command, frame_reg.slave};
    assign m_tuser  = out_bvalid_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        busy_next       = busy_reg;
        frame_next      = frame_reg;
        iss_cnt_next    = iss_cnt_reg;
        pend_next       = pend_reg;
        pend_last_next  = pend_last_reg;
        pend_empty_next = pend_empty_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_bvalid_next = out_bvalid_reg;
        out_last_next   = out_last_reg;

        if (can_move) begin
            out_valid_next  = 1'b1;
            out_byte_next   = pend_empty_reg ? '0 : ram_rdata;
            out_bvalid_next = !pend_empty_reg;
            out_last_next   = pend_last_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (can_issue) begin
            iss_cnt_next    = iss_cnt_reg + 1'b1;
            pend_next       = 1'b1;
            pend_last_next  = (iss_cnt_next == n_items);
            pend_empty_next = (frame_reg.length == '0);
        end else if (can_move) begin
            pend_next = 1'b0;
        end

        if (last_taken) begin
            busy_next = 1'b0;
        end

        if (emit_start) begin
            busy_next    = 1'b1;
            frame_next   = emit_frame;
            iss_cnt_next = '0;
            pend_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg      <= frame_next;
        iss_cnt_reg    <= iss_cnt_next;
        pend_last_reg  <= pend_last_next;
        pend_empty_reg <= pend_empty_next;
        out_byte_reg   <= out_byte_next;
        out_bvalid_reg <= out_bvalid_next;
        out_last_reg   <= out_last_next;
    end

    // a new frame only arrives once the previous readout is over
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_start |-> !busy_reg)
        else $error("frame start while readout busy");

    // no word leaves outside a readout
    a_valid_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg || pend_reg) |-> busy_reg)
        else $error("output word outside readout");

    // reads never run past the frame length
    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (iss_cnt_reg <= n_items))
        else $error("read count past frame length");

    // taking the last word ends the readout with nothing left behind
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        last_taken |=> (!busy_reg && !pend_reg && !out_valid_reg))
        else $error("readout still active after last word");

endmodule

[rtl/framed_packet_receiver_core.sv]
// top level of the framed packet receiver: config registers, parser, payload ram, emitter
//
// Takes one received byte per word on the s_ channel. It hunts for the start byte 0x3A, then
// reads slave address, command, length, the payload, a big-endian 16-bit checksum and the end
// byte 0x0D. The checksum is the wrapping 16-bit sum of start, slave, command, length, payload
// and end bytes. A frame with a good end byte, a matching checksum and a slave address equal
// to the own address register (or any address when the own address equals the listen-all
// address) is replayed on the m_ channel as one word per payload byte, m_tlast on the final
// one; a frame with an empty payload gives a single word with m_tuser low. Failed frames and
// frames longer than 64 payload bytes are consumed and dropped without any output. A start
// byte inside a frame is plain data. The payload goes into a 64 x 8 synchronous ram and is
// read back after the end byte at one word per cycle while m_tready stays high, each word
// passing through the ram read register and then the output register. During that readout
// s_tready is low, so the input is held off until the last word is taken. Ram writes (while
// receiving) and reads (while replaying) never overlap, so no forwarding is needed. Config
// writes are taken any time but should only happen while the block is idle.
module framed_packet_receiver_core
    import frp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // config write port
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [BYTE_W-1:0]  cfg_wdata,
    // received bytes
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] rx_byte
    // payload words
    output logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] slave_id, [15:8] command, [22:16] payload_length, [30:23] payload_byte, [31] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser,   // [0] byte_valid
    output logic               m_tlast
);

    logic [BYTE_W-1:0] board_addr_reg;
    logic [BYTE_W-1:0] listen_addr_reg;

    logic              emit_busy;
    logic              emit_start;
    frame_t            emit_frame;

    logic              ram_we;
    logic [PAY_AW-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [PAY_AW-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    // config registers, listen-all address resets to all ones
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            board_addr_reg  <= '0;
            listen_addr_reg <= '1;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_BOARD_ADDR:  board_addr_reg  <= cfg_wdata;
                CFG_LISTEN_ADDR: listen_addr_reg <= cfg_wdata;
                default:         board_addr_reg  <= board_addr_reg;
            endcase
        end
    end

    // byte parser, writes payload into the ram as it arrives
    frp_parser u_parser (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .own_addr           (board_addr_reg),
        .listen_all_address (listen_addr_reg),
        .emit_busy          (emit_busy),
        .ram_we             (ram_we),
        .ram_waddr          (ram_waddr),
        .ram_wdata          (ram_wdata),
        .emit_start         (emit_start),
        .emit_frame         (emit_frame)
    );

    // payload store
    frp_payload_ram #(
        .WIDTH  (BYTE_W),
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (PAY_AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // readout of an accepted frame
    frp_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .emit_start (emit_start),
        .emit_frame (emit_frame),
        .emit_busy  (emit_busy),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
